// ===== src/rtm_pkg.sv =====
// Shared definitions for the extended Reinhard tone mapper.
// Holds default widths, opcodes, state encodings and lane control/status structs.
package rtm_pkg;

    localparam int RTM_IN_BITS   = 24;
    localparam int RTM_FRAC_BITS = 16;
    localparam int RTM_LANES     = 3;
    // digit width of the shift-add multiplier in each lane
    localparam int RTM_DIG_W     = 8;

    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_MAP     = 1'b1;

    typedef enum logic [2:0] {
        L_IDLE,
        L_SQUARE,
        L_SETUP,
        L_MUL,
        L_CHECK,
        L_DIV,
        L_DONE
    } t_lane_state;

    typedef enum logic {
        T_IDLE,
        T_BUSY
    } t_top_state;

    typedef struct packed {
        logic start;
        logic ack;
    } t_lane_ctl;

    typedef struct packed {
        logic done;
        logic clip;
    } t_lane_sts;

endpackage

// ===== src/rtm_if.sv =====
// Valid/ready stream interfaces for pixel input and tone mapped output.
// Depends on rtm_pkg for default widths.
interface rtm_in_if import rtm_pkg::*; #(
    parameter int IN_BITS = RTM_IN_BITS
) ();
    logic               valid;
    logic               ready;
    logic               opcode;
    logic               first;
    logic [IN_BITS-1:0] red;
    logic [IN_BITS-1:0] green;
    logic [IN_BITS-1:0] blue;

    modport source (output valid, opcode, first, red, green, blue, input ready);
    modport sink   (input valid, opcode, first, red, green, blue, output ready);
endinterface

interface rtm_out_if import rtm_pkg::*; #(
    parameter int FRAC_BITS = RTM_FRAC_BITS
) ();
    logic               valid;
    logic               ready;
    logic [FRAC_BITS:0] red_out;
    logic [FRAC_BITS:0] green_out;
    logic [FRAC_BITS:0] blue_out;
    logic               clipped;

    modport source (output valid, red_out, green_out, blue_out, clipped, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, clipped, output ready);
endinterface

// ===== src/rtm_lane.sv =====
// One channel lane: squares the white, forms numerator and denominator with a digit-serial
// multiplier, then runs a restoring divider unless the white is zero or the value saturates. Depends on rtm_pkg.
module rtm_lane import rtm_pkg::*; #(
    parameter int IN_BITS   = RTM_IN_BITS,
    parameter int FRAC_BITS = RTM_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_lane_ctl          i_ctl,
    input  logic [IN_BITS-1:0] i_c,
    input  logic [IN_BITS-1:0] i_w,
    output t_lane_sts          o_sts,
    output logic [FRAC_BITS:0] o_q
);

    localparam int S_W   = ((2*IN_BITS > IN_BITS+FRAC_BITS) ? 2*IN_BITS
                                                            : IN_BITS+FRAC_BITS) + 1;
    localparam int ACC_W = S_W + IN_BITS;
    localparam int NDIG  = (IN_BITS + RTM_DIG_W - 1) / RTM_DIG_W;
    localparam int MPL_W = NDIG * RTM_DIG_W;
    localparam int CNT_W = $clog2(FRAC_BITS + 1);
    localparam int Q_W   = FRAC_BITS + 1;

    t_lane_state          r_state, n_state;
    logic [IN_BITS-1:0]   r_c, n_c;
    logic [IN_BITS-1:0]   r_w, n_w;
    logic [2*IN_BITS-1:0] r_w2, n_w2;
    logic [ACC_W-1:0]     r_mcn, n_mcn;
    logic [ACC_W-1:0]     r_mcd, n_mcd;
    logic [ACC_W-1:0]     r_acc_n, n_acc_n;
    logic [ACC_W-1:0]     r_acc_d, n_acc_d;
    logic [MPL_W-1:0]     r_mpl, n_mpl;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [Q_W-1:0]       r_q, n_q;
    logic                 r_clip, n_clip;

    logic [ACC_W+RTM_DIG_W-1:0] w_pn;
    logic [ACC_W+RTM_DIG_W-1:0] w_pd;
    logic [ACC_W:0]             w_trial;
    logic [ACC_W:0]             w_diff;
    logic                       w_ge;

    assign w_pn    = r_mcn * r_mpl[RTM_DIG_W-1:0];
    assign w_pd    = r_mcd * r_mpl[RTM_DIG_W-1:0];
    // first quotient bit compares the remainder unshifted
    assign w_trial = (r_cnt == '0) ? {1'b0, r_acc_n} : {r_acc_n, 1'b0};
    assign w_ge    = w_trial >= {1'b0, r_acc_d};
    assign w_diff  = w_trial - {1'b0, r_acc_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c     <= n_c;
        r_w     <= n_w;
        r_w2    <= n_w2;
        r_mcn   <= n_mcn;
        r_mcd   <= n_mcd;
        r_acc_n <= n_acc_n;
        r_acc_d <= n_acc_d;
        r_mpl   <= n_mpl;
        r_cnt   <= n_cnt;
        r_q     <= n_q;
        r_clip  <= n_clip;
    end

    always_comb begin
        n_state = r_state;
        n_c     = r_c;
        n_w     = r_w;
        n_w2    = r_w2;
        n_mcn   = r_mcn;
        n_mcd   = r_mcd;
        n_acc_n = r_acc_n;
        n_acc_d = r_acc_d;
        n_mpl   = r_mpl;
        n_cnt   = r_cnt;
        n_q     = r_q;
        n_clip  = r_clip;
        unique case (r_state)
            L_IDLE: begin
                if (i_ctl.start) begin
                    n_c     = i_c;
                    n_w     = i_w;
                    n_state = L_SQUARE;
                end
            end
            L_SQUARE: begin
                n_w2    = r_w * r_w;
                n_state = L_SETUP;
            end
            L_SETUP: begin
                // numerator factor W^2 + C*F, denominator W^2*(F + C) seeded with W^2*F
                n_mcn   = ACC_W'(r_w2) + (ACC_W'(r_c) << FRAC_BITS);
                n_mcd   = ACC_W'(r_w2);
                n_acc_n = '0;
                n_acc_d = ACC_W'(r_w2) << FRAC_BITS;
                n_mpl   = MPL_W'(r_c);
                n_cnt   = '0;
                n_state = L_MUL;
            end
            L_MUL: begin
                n_acc_n = r_acc_n + w_pn[ACC_W-1:0];
                n_acc_d = r_acc_d + w_pd[ACC_W-1:0];
                n_mcn   = r_mcn << RTM_DIG_W;
                n_mcd   = r_mcd << RTM_DIG_W;
                n_mpl   = r_mpl >> RTM_DIG_W;
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NDIG - 1)) begin
                    n_state = L_CHECK;
                end
            end
            L_CHECK: begin
                n_cnt  = '0;
                n_q    = '0;
                n_clip = 1'b0;
                if (r_w == '0) begin
                    n_state = L_DONE;
                end else if (r_acc_n > r_acc_d) begin
                    // exact value above one: saturate
                    n_clip  = 1'b1;
                    n_q     = Q_W'(1) << FRAC_BITS;
                    n_state = L_DONE;
                end else begin
                    n_state = L_DIV;
                end
            end
            L_DIV: begin
                n_acc_n = w_ge ? w_diff[ACC_W-1:0] : w_trial[ACC_W-1:0];
                n_q     = {r_q[Q_W-2:0], w_ge};
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(FRAC_BITS)) begin
                    n_state = L_DONE;
                end
            end
            L_DONE: begin
                // hold the result until the merge stage takes it
                if (i_ctl.ack) begin
                    n_state = L_IDLE;
                end
            end
            default: begin
                n_state = L_IDLE;
            end
        endcase
    end

    assign o_sts.done = (r_state == L_DONE);
    assign o_sts.clip = r_clip;
    assign o_q        = r_q;

`ifndef SYNTH
    a_clip_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == L_DONE && r_clip) |-> (r_q == (Q_W'(1) << FRAC_BITS)))
        else $error("clipped lane result is not full scale");

    a_q_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == L_DONE) |-> (r_q <= (Q_W'(1) << FRAC_BITS)))
        else $error("lane quotient above one");

    a_zero_white: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == L_DONE && r_w == '0) |-> (r_q == '0 && !r_clip))
        else $error("zero white did not give zero");
`endif

endmodule

// ===== src/rtm_merge.sv =====
// Merge stage: combines the lane results and clip flags into the output register.
// Depends on rtm_pkg and rtm_out_if.
module rtm_merge import rtm_pkg::*; #(
    parameter int FRAC_BITS = RTM_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_lane_sts          i_sts [RTM_LANES],
    input  logic [FRAC_BITS:0] i_q [RTM_LANES],
    output logic               o_take,
    rtm_out_if.source          o_map
);

    logic               r_valid;
    logic [FRAC_BITS:0] r_q [RTM_LANES];
    logic               r_clip;
    logic               w_all_done;
    logic               w_clip_any;

    always_comb begin
        w_all_done = 1'b1;
        w_clip_any = 1'b0;
        for (int k = 0; k < RTM_LANES; k++) begin
            w_all_done = w_all_done & i_sts[k].done;
            w_clip_any = w_clip_any | i_sts[k].clip;
        end
    end

    // load when the register is empty or its transfer completes this cycle
    assign o_take = w_all_done && (!r_valid || o_map.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= 1'b1;
        end else if (o_map.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_q    <= i_q;
            r_clip <= w_clip_any;
        end
    end

    assign o_map.valid     = r_valid;
    assign o_map.red_out   = r_q[0];
    assign o_map.green_out = r_q[1];
    assign o_map.blue_out  = r_q[2];
    assign o_map.clipped   = r_clip;

endmodule

// ===== src/reinhard_extended_tone_map.sv =====
// Extended Reinhard tone mapper, three channel lanes and one merge stage.
// Measure item: updates the white points only; the next item may follow in the next cycle.
// Map item: the lanes square the white, multiply and divide (no divide on zero white or
// saturation); the next item is taken after the merge stage takes the lane results. A result
// held in the output register and not yet transferred blocks that take, and so the next item.
// Synchronous active-low reset clears white points, lane and output control state.
module reinhard_extended_tone_map import rtm_pkg::*; #(
    parameter int IN_BITS   = RTM_IN_BITS,
    parameter int FRAC_BITS = RTM_FRAC_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rtm_in_if.sink    i_pix,
    rtm_out_if.source o_map
);

    t_top_state         r_state, n_state;
    logic [IN_BITS-1:0] r_white [RTM_LANES];
    logic [IN_BITS-1:0] n_white [RTM_LANES];
    logic [IN_BITS-1:0] w_c [RTM_LANES];
    logic [FRAC_BITS:0] w_q [RTM_LANES];
    t_lane_sts          w_sts [RTM_LANES];
    t_lane_ctl          w_ctl;
    logic               w_accept;
    logic               w_take;

    assign w_c[0] = i_pix.red;
    assign w_c[1] = i_pix.green;
    assign w_c[2] = i_pix.blue;

    assign i_pix.ready = (r_state == T_IDLE);
    assign w_accept    = i_pix.valid && i_pix.ready;
    assign w_ctl.start = w_accept && (i_pix.opcode == OP_MAP);
    assign w_ctl.ack   = w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            for (int k = 0; k < RTM_LANES; k++) begin
                r_white[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_white <= n_white;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            T_IDLE: begin
                if (w_ctl.start) begin
                    n_state = T_BUSY;
                end
            end
            T_BUSY: begin
                if (w_take) begin
                    n_state = T_IDLE;
                end
            end
            default: begin
                n_state = T_IDLE;
            end
        endcase
    end

    // running maximum; first restarts it from this pixel
    always_comb begin
        for (int k = 0; k < RTM_LANES; k++) begin
            n_white[k] = r_white[k];
            if (w_accept && i_pix.opcode == OP_MEASURE) begin
                if (i_pix.first || w_c[k] > r_white[k]) begin
                    n_white[k] = w_c[k];
                end
            end
        end
    end

    for (genvar g = 0; g < RTM_LANES; g++) begin : g_lane
        rtm_lane #(
            .IN_BITS   (IN_BITS),
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_c     (w_c[g]),
            .i_w     (r_white[g]),
            .o_sts   (w_sts[g]),
            .o_q     (w_q[g])
        );
    end

    rtm_merge #(
        .FRAC_BITS (FRAC_BITS)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .i_q     (w_q),
        .o_take  (w_take),
        .o_map   (o_map)
    );

endmodule

// ===== bench/tb_reinhard_extended_tone_map.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the extended Reinhard tone mapper: measure/map streams in, toned pixels out.
// Depends on rtm_pkg and the rtm_in_if / rtm_out_if stream interfaces.
module tb_reinhard_extended_tone_map;
    import rtm_pkg::*;

    localparam int IB           = RTM_IN_BITS;
    localparam int FB           = RTM_FRAC_BITS;
    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 12;
    localparam int MAX_WAIT     = 17;
    localparam int RANDOM_ITEMS = 1400;
    localparam int DRAIN_CYCLES = 64;
    localparam int LIMIT_CYCLES = 500000;

    typedef logic [IB-1:0] t_chan;
    typedef logic [FB:0]   t_tone;

    localparam t_tone TONE_ONE = t_tone'(1) << FB;

    typedef struct packed {
        logic  opcode;
        logic  first;
        t_chan red;
        t_chan green;
        t_chan blue;
    } t_pixel;

    typedef struct packed {
        t_tone red;
        t_tone green;
        t_tone blue;
        logic  clipped;
    } t_toned;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    rtm_in_if  pix_if ();
    rtm_out_if map_if ();

    reinhard_extended_tone_map u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_map   (map_if)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    t_pixel pixel_queue[$];
    t_toned pending_tones[$];
    t_chan  peak_r, peak_g, peak_b;
    int     n_total, n_accepted, n_measure, n_map, n_checked, n_clipped, n_unity;
    int     errors, cycles;
    int     src_gap, snk_gap;
    bit     src_calm, snk_calm;
    logic   in_taken, out_taken;

    // Exact c*(1+c/w^2)/(1+c) on raw fixed-point values, truncated, saturating at 1.0.
    function automatic t_tone tone_channel(input t_chan c, input t_chan w, inout logic clip);
        logic [127:0] w2, num, den;
        if (w == '0)
            return '0;
        w2  = 128'(w) * 128'(w);
        num = (128'(c) << FB) * (w2 + (128'(c) << FB));
        den = w2 * ((128'(1) << FB) + 128'(c));
        if (num > (den << FB)) begin
            clip = 1'b1;
            return TONE_ONE;
        end
        return t_tone'(num / den);
    endfunction

    function automatic t_toned tone_pixel(input t_pixel p);
        t_toned t;
        t.clipped = 1'b0;
        t.red     = tone_channel(p.red,   peak_r, t.clipped);
        t.green   = tone_channel(p.green, peak_g, t.clipped);
        t.blue    = tone_channel(p.blue,  peak_b, t.clipped);
        return t;
    endfunction

    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 39) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic t_chan rand_chan();
        case ($urandom_range(0, 6))
            0: return '0;
            1: return '1;
            2: return t_chan'($urandom_range(0, 255));
            3: return t_chan'($urandom) >> $urandom_range(0, IB - 1);
            default: return t_chan'($urandom);
        endcase
    endfunction

    task automatic push_pixel(input logic op, input logic fst, input t_chan r, input t_chan g,
                              input t_chan b);
        t_pixel p;
        p.opcode = op;
        p.first  = fst;
        p.red    = r;
        p.green  = g;
        p.blue   = b;
        pixel_queue.push_back(p);
    endtask

    task automatic check_field(input string name, input t_tone want, input t_tone got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Input driver: hold an item until transfer, then idle for the drawn gap.
    always @(negedge i_clk) begin
        t_pixel nxt;
        if (!i_rst_n) begin
            pix_if.valid <= 1'b0;
        end else if (pix_if.valid && !in_taken) begin
            // hold
        end else if (src_gap > 0) begin
            src_gap--;
            pix_if.valid <= 1'b0;
        end else if (pixel_queue.size() > 0) begin
            nxt = pixel_queue.pop_front();
            pix_if.opcode <= nxt.opcode;
            pix_if.first  <= nxt.first;
            pix_if.red    <= nxt.red;
            pix_if.green  <= nxt.green;
            pix_if.blue   <= nxt.blue;
            pix_if.valid  <= 1'b1;
            src_gap = draw_wait(src_calm);
        end else begin
            pix_if.valid <= 1'b0;
        end
    end

    // Output side: stall for a drawn number of cycles after each result.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            map_if.ready <= 1'b0;
        end else begin
            if (out_taken)
                snk_gap = draw_wait(snk_calm);
            if (snk_gap > 0) begin
                snk_gap--;
                map_if.ready <= 1'b0;
            end else begin
                map_if.ready <= 1'b1;
            end
        end
    end

    // Monitor: predict on input transfers, compare on output transfers.
    always @(posedge i_clk) begin
        t_pixel p;
        t_toned want;
        cycles++;
        in_taken  <= i_rst_n && pix_if.valid && pix_if.ready;
        out_taken <= i_rst_n && map_if.valid && map_if.ready;
        if (i_rst_n && pix_if.valid && pix_if.ready) begin
            p.opcode = pix_if.opcode;
            p.first  = pix_if.first;
            p.red    = pix_if.red;
            p.green  = pix_if.green;
            p.blue   = pix_if.blue;
            n_accepted++;
            if (p.opcode == OP_MEASURE) begin
                n_measure++;
                if (p.first) begin
                    peak_r = '0;
                    peak_g = '0;
                    peak_b = '0;
                end
                if (p.red > peak_r)
                    peak_r = p.red;
                if (p.green > peak_g)
                    peak_g = p.green;
                if (p.blue > peak_b)
                    peak_b = p.blue;
            end else begin
                n_map++;
                pending_tones.push_back(tone_pixel(p));
            end
        end
        if (i_rst_n && map_if.valid && map_if.ready) begin
            if (pending_tones.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected, actual r=%0d g=%0d b=%0d clip=%0b",
                         $time, map_if.red_out, map_if.green_out, map_if.blue_out,
                         map_if.clipped);
            end else begin
                want = pending_tones.pop_front();
                n_checked++;
                if (want.clipped)
                    n_clipped++;
                if (want.red == TONE_ONE || want.green == TONE_ONE || want.blue == TONE_ONE)
                    n_unity++;
                check_field("red_out",   want.red,     map_if.red_out);
                check_field("green_out", want.green,   map_if.green_out);
                check_field("blue_out",  want.blue,    map_if.blue_out);
                check_field("clipped",   t_tone'(want.clipped), t_tone'(map_if.clipped));
            end
        end
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d of %0d items taken, %0d results pending",
                     cycles, n_accepted, n_total, pending_tones.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        t_pixel frame[$];
        t_pixel px;
        int     n_frame, n_keep, n_directed;

        pix_if.valid  = 1'b0;
        pix_if.opcode = OP_MEASURE;
        pix_if.first  = 1'b0;
        pix_if.red    = '0;
        pix_if.green  = '0;
        pix_if.blue   = '0;
        map_if.ready  = 1'b0;
        peak_r = '0;
        peak_g = '0;
        peak_b = '0;

        // map before any measure: white is zero everywhere
        push_pixel(OP_MAP, 1'b0, '1, '1, '1);
        push_pixel(OP_MAP, 1'b1, '0, 24'd12345, '1);
        // full-scale white: equal channel lands exactly on one
        push_pixel(OP_MEASURE, 1'b1, '1, '1, '1);
        push_pixel(OP_MAP, 1'b0, '1, '1, '1);
        push_pixel(OP_MAP, 1'b0, '0, '0, '0);
        push_pixel(OP_MAP, 1'b0, 24'd1, 24'h010000, 24'h7fffff);
        // tiny and zero whites, channels above white saturate
        push_pixel(OP_MEASURE, 1'b1, 24'd1, '0, 24'h010000);
        push_pixel(OP_MAP, 1'b0, 24'd1, '1, 24'h010000);
        push_pixel(OP_MAP, 1'b0, 24'd2, 24'd5, 24'h010001);
        push_pixel(OP_MAP, 1'b0, '0, '0, '0);
        // first on a map item leaves the white point alone
        push_pixel(OP_MAP, 1'b1, 24'd1, '0, 24'd1);
        push_pixel(OP_MAP, 1'b0, 24'd1, '0, 24'd1);
        push_pixel(OP_MEASURE, 1'b0, 24'd3, 24'd7, 24'd100);
        push_pixel(OP_MAP, 1'b0, 24'd3, 24'd7, 24'h008000);
        // running max grows, then a restart drops it
        push_pixel(OP_MEASURE, 1'b1, 24'd100, 24'd200, 24'd300);
        push_pixel(OP_MEASURE, 1'b0, 24'd50, 24'd400, '0);
        push_pixel(OP_MAP, 1'b0, 24'd100, 24'd400, 24'd150);
        push_pixel(OP_MEASURE, 1'b1, 24'd10, 24'd10, 24'd10);
        push_pixel(OP_MAP, 1'b0, 24'd10, 24'd20, 24'd5);
        // large white, tiny channel
        push_pixel(OP_MEASURE, 1'b1, '1, 24'h800000, 24'h010000);
        push_pixel(OP_MAP, 1'b0, 24'd1, 24'd1, 24'd1);
        push_pixel(OP_MAP, 1'b0, 24'hfffffe, 24'h800001, 24'h00ffff);
        n_directed = pixel_queue.size();

        // mostly whole frames streamed twice; some noise and cut-short passes
        while (pixel_queue.size() - n_directed < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                push_pixel(logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)),
                           rand_chan(), rand_chan(), rand_chan());
            end else begin
                frame.delete();
                n_frame = $urandom_range(1, 10);
                for (int i = 0; i < n_frame; i++) begin
                    px.opcode = OP_MEASURE;
                    px.first  = (i == 0) && ($urandom_range(0, 7) != 0);
                    px.red    = rand_chan();
                    px.green  = rand_chan();
                    px.blue   = rand_chan();
                    frame.push_back(px);
                    pixel_queue.push_back(px);
                end
                n_keep = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n_frame) : n_frame;
                for (int i = 0; i < n_keep; i++) begin
                    px        = frame[i];
                    px.opcode = OP_MAP;
                    px.first  = logic'($urandom_range(0, 1));
                    if ($urandom_range(0, 5) == 0)
                        px.green = rand_chan();
                    pixel_queue.push_back(px);
                end
            end
        end
        n_total = pixel_queue.size();

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(negedge i_clk);
        while (n_accepted < n_total || pending_tones.size() > 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("covered %0d measure and %0d map transfers in %0d cycles", n_measure, n_map,
                 cycles);
        $display("checked %0d toned pixels, %0d clipped, %0d with a channel at exactly one",
                 n_checked, n_clipped, n_unity);
        if (errors == 0 && pending_tones.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
